// ===== rtl/core/aplf_pkg.sv =====
// Package with the types, codes and constants of the automatic pointer-layer controller.
`timescale 1ns / 1ps

package aplf_pkg;

    localparam int MASK_BITS_DEFAULT = 32;
    localparam int TIME_BITS_DEFAULT = 16;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [1:0] REG_ENABLE     = 2'd0;
    localparam logic [1:0] REG_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_RESET_TIME = 2'd2;

    localparam logic        ENABLE_RESET     = 1'b1;
    localparam logic [14:0] THRESHOLD_RESET  = 15'd50;
    localparam logic [9:0]  RESET_TIME_RESET = 10'd10;

    localparam logic [1:0] OP_POINTER = 2'd0;
    localparam logic [1:0] OP_KEY     = 2'd1;
    localparam logic [1:0] OP_LAYER   = 2'd2;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_ON   = 2'd1;
    localparam logic [1:0] CMD_OFF  = 2'd2;

    localparam logic [31:0] PTR_LAYER_BIT   = 32'h0000_0002;
    localparam logic [31:0] SCROLL_LOW_BITS = 32'h0000_000F;
    localparam int          SCROLL_LAYER    = 3;

    localparam logic [15:0] WAIT_TIMEOUT_MS = 16'd50;
    localparam logic [16:0] TENTH_MS        = 17'd100;
    localparam logic [14:0] ACC_MAX         = 15'h7FFF;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WAIT  = 2'd1,
        ST_CLICK = 2'd2
    } click_state_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [15:0]       now_ms;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic              base_on_top;
        logic [31:0]       layer_mask_in;
    } item_t;

    typedef struct packed {
        logic [1:0]  layer_cmd;
        logic [31:0] layer_mask_out;
        logic        scroll_mode;
        logic [1:0]  click_state_out;
        logic [14:0] motion_total;
    } result_t;

endpackage

// ===== rtl/core/auto_pointer_layer_fsm_unit.sv =====
// Top level of the automatic pointer-layer controller: input stage, state machine, result stage.
`timescale 1ns / 1ps

// The block takes pointer reports, key presses and layer changes on the item channel
// (item_valid, item_ready, item) and returns exactly one result per transaction on the
// result channel (result_valid, result_ready, result), in order.
// An accepted transaction sits in the input register, where the state machine
// and the motion accumulator work on it, and its result is held in the result register.
// One transaction is accepted per cycle unless the receiver stalls; the limit is the
// single state update per cycle.
// When the receiver stalls, the result register holds and the input register keeps the
// next transaction, so item_ready drops only when both are full.
// Reset clears both stages, puts the controller in the idle state with a zero timer
// stamp and a zero accumulator, and loads the register defaults: enable on,
// threshold 50 and a clickable timeout of 10 tenths of a second.
// The APB port holds the enable bit at 0x0, the motion threshold at 0x4 and the
// clickable timeout at 0x8; write it only while no transaction is in flight.
module auto_pointer_layer_fsm_unit #(
    parameter int MASK_BITS = aplf_pkg::MASK_BITS_DEFAULT,
    parameter int TIME_BITS = aplf_pkg::TIME_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [aplf_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [aplf_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [aplf_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,

    input  logic                               item_valid,
    output logic                               item_ready,
    input  aplf_pkg::item_t                    item,

    output logic                               result_valid,
    input  logic                               result_ready,
    output aplf_pkg::result_t                  result
);

    logic                   cfg_enable_reg;
    logic [14:0]            cfg_threshold_reg;
    logic [9:0]             cfg_reset_time_reg;
    logic                   cfg_write;

    logic                   pipe_valid_reg;
    aplf_pkg::item_t        pipe_data_reg;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    aplf_pkg::result_t      result_reg;
    aplf_pkg::result_t      result_next;
    logic                   advance;

    aplf_pkg::click_state_t state_reg;
    aplf_pkg::click_state_t state_next;
    logic [TIME_BITS-1:0]   stamp_reg;
    logic [TIME_BITS-1:0]   stamp_next;
    logic [14:0]            acc_reg;
    logic [14:0]            acc_next;

    logic [TIME_BITS-1:0]   now_t;
    logic [TIME_BITS-1:0]   elapsed;
    logic [7:0]             mag_x;
    logic [7:0]             mag_y;
    logic                   has_motion;
    logic [15:0]            acc_sum;
    logic [14:0]            acc_sat;
    logic [16:0]            click_limit;
    logic                   click_expired;
    logic                   wait_expired;
    logic [MASK_BITS-1:0]   mask_in;
    logic [MASK_BITS-1:0]   mask_filt;
    logic [MASK_BITS-1:0]   ptr_bit;
    logic [MASK_BITS-1:0]   scroll_low;
    logic [1:0]             cmd;
    logic [MASK_BITS-1:0]   mask_out;
    logic                   scroll;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_enable_reg     <= aplf_pkg::ENABLE_RESET;
            cfg_threshold_reg  <= aplf_pkg::THRESHOLD_RESET;
            cfg_reset_time_reg <= aplf_pkg::RESET_TIME_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                aplf_pkg::REG_ENABLE:     cfg_enable_reg     <= pwdata[0];
                aplf_pkg::REG_THRESHOLD:  cfg_threshold_reg  <= pwdata[14:0];
                aplf_pkg::REG_RESET_TIME: cfg_reset_time_reg <= pwdata[9:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            aplf_pkg::REG_ENABLE:     prdata = 32'(cfg_enable_reg);
            aplf_pkg::REG_THRESHOLD:  prdata = 32'(cfg_threshold_reg);
            aplf_pkg::REG_RESET_TIME: prdata = 32'(cfg_reset_time_reg);
            default:                  prdata = '0;
        endcase
    end

    // Handshake and stage control.
    assign advance           = pipe_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready        = !pipe_valid_reg || advance;
    assign result_valid_next = advance || (result_valid_reg && !result_ready);
    assign result_valid      = result_valid_reg;
    assign result            = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                pipe_valid_reg <= item_valid;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            pipe_data_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aplf_pkg::ST_IDLE;
            stamp_reg <= '0;
            acc_reg   <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            stamp_reg <= stamp_next;
            acc_reg   <= acc_next;
        end
    end

    // Datapath terms of the transaction in the input register.
    assign now_t      = TIME_BITS'(pipe_data_reg.now_ms);
    assign elapsed    = now_t - stamp_reg;
    assign mag_x      = pipe_data_reg.dx[7] ? 8'(~pipe_data_reg.dx + 8'd1) : pipe_data_reg.dx;
    assign mag_y      = pipe_data_reg.dy[7] ? 8'(~pipe_data_reg.dy + 8'd1) : pipe_data_reg.dy;
    assign has_motion = (mag_x != 8'd0) || (mag_y != 8'd0);
    assign acc_sum    = 16'(acc_reg) + 16'(mag_x) + 16'(mag_y);
    assign acc_sat    = (acc_sum > 16'(aplf_pkg::ACC_MAX)) ? aplf_pkg::ACC_MAX : acc_sum[14:0];

    assign click_limit   = 17'(cfg_reset_time_reg) * aplf_pkg::TENTH_MS;
    assign click_expired = 33'(elapsed) > 33'(click_limit);
    assign wait_expired  = 33'(elapsed) > 33'(aplf_pkg::WAIT_TIMEOUT_MS);

    assign mask_in    = pipe_data_reg.layer_mask_in[MASK_BITS-1:0];
    assign ptr_bit    = MASK_BITS'(aplf_pkg::PTR_LAYER_BIT);
    assign scroll_low = MASK_BITS'(aplf_pkg::SCROLL_LOW_BITS);

    // Next state and result.
    always_comb
    begin
        state_next = state_reg;
        stamp_next = stamp_reg;
        acc_next   = acc_reg;
        cmd        = aplf_pkg::CMD_NONE;
        mask_filt  = mask_in;
        mask_out   = '0;
        scroll     = 1'b0;

        case (pipe_data_reg.opcode)
            aplf_pkg::OP_POINTER:
            begin
                if (has_motion)
                begin
                    case (state_reg)
                        aplf_pkg::ST_CLICK:
                        begin
                            stamp_next = now_t;
                        end
                        aplf_pkg::ST_WAIT:
                        begin
                            if (cfg_enable_reg && pipe_data_reg.base_on_top)
                            begin
                                if (acc_sat >= cfg_threshold_reg)
                                begin
                                    acc_next   = '0;
                                    stamp_next = now_t;
                                    state_next = aplf_pkg::ST_CLICK;
                                    cmd        = aplf_pkg::CMD_ON;
                                end
                                else
                                begin
                                    acc_next = acc_sat;
                                end
                            end
                        end
                        default:
                        begin
                            stamp_next = now_t;
                            state_next = aplf_pkg::ST_WAIT;
                            acc_next   = '0;
                        end
                    endcase
                end
                else
                begin
                    case (state_reg)
                        aplf_pkg::ST_CLICK:
                        begin
                            if (click_expired)
                            begin
                                state_next = aplf_pkg::ST_IDLE;
                                cmd        = aplf_pkg::CMD_OFF;
                            end
                        end
                        aplf_pkg::ST_WAIT:
                        begin
                            if (wait_expired)
                            begin
                                acc_next   = '0;
                                state_next = aplf_pkg::ST_IDLE;
                            end
                        end
                        default:
                        begin
                            acc_next   = '0;
                            state_next = aplf_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            aplf_pkg::OP_KEY:
            begin
                if (state_reg == aplf_pkg::ST_CLICK)
                begin
                    stamp_next = now_t;
                    cmd        = aplf_pkg::CMD_ON;
                end
            end
            aplf_pkg::OP_LAYER:
            begin
                if (state_reg == aplf_pkg::ST_CLICK)
                begin
                    state_next = aplf_pkg::ST_IDLE;
                    if ((mask_in & ~ptr_bit) != '0)
                    begin
                        mask_filt = mask_in & ~ptr_bit;
                    end
                end
                mask_out = mask_filt;
                scroll   = mask_filt[aplf_pkg::SCROLL_LAYER] && ((mask_filt & ~scroll_low) == '0);
            end
            default:
            begin
                cmd = aplf_pkg::CMD_NONE;
            end
        endcase

        result_next.layer_cmd       = cmd;
        result_next.layer_mask_out  = 32'(mask_out);
        result_next.scroll_mode     = scroll;
        result_next.click_state_out = state_next;
        result_next.motion_total    = acc_next;
    end

    // The accumulator only holds a count while the controller is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != aplf_pkg::ST_WAIT) |-> (acc_reg == '0))
        else $error("motion accumulator is nonzero outside the waiting state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.layer_cmd == aplf_pkg::CMD_ON)
            |-> (result.click_state_out == 2'(aplf_pkg::ST_CLICK)))
        else $error("layer on command without the clickable state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.layer_cmd == aplf_pkg::CMD_OFF)
            |-> (result.click_state_out == 2'(aplf_pkg::ST_IDLE)))
        else $error("layer off command without the idle state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_valid_reg && !advance) |=> (pipe_valid_reg && $stable(state_reg)))
        else $error("stalled transaction lost or state changed during stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("advanced transaction did not reach the result register");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the automatic pointer-layer controller with a scoreboard class.
`timescale 1ns / 1ps

class pointer_layer_scoreboard;
    logic                   enable;
    logic [14:0]            threshold;
    logic [9:0]             reset_tenths;
    aplf_pkg::click_state_t state;
    logic [15:0]            stamp;
    logic [14:0]            motion;
    aplf_pkg::result_t      expected_results[$];
    int unsigned            errors;
    int unsigned            checked;
    int unsigned            layer_on_count;
    int unsigned            layer_off_count;

    function new();
        enable = aplf_pkg::ENABLE_RESET;
        threshold = aplf_pkg::THRESHOLD_RESET;
        reset_tenths = aplf_pkg::RESET_TIME_RESET;
        state = aplf_pkg::ST_IDLE;
        stamp = '0;
        motion = '0;
        errors = 0;
        checked = 0;
        layer_on_count = 0;
        layer_off_count = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [31:0] value);
        case (index)
            aplf_pkg::REG_ENABLE:     enable = value[0];
            aplf_pkg::REG_THRESHOLD:  threshold = value[14:0];
            aplf_pkg::REG_RESET_TIME: reset_tenths = value[9:0];
            default:                  ;
        endcase
    endfunction

    function aplf_pkg::result_t step_controller(aplf_pkg::item_t it);
        aplf_pkg::result_t r;
        logic [7:0]        ax;
        logic [7:0]        ay;
        logic [15:0]       elapsed;
        logic [15:0]       sum;
        logic [16:0]       click_limit;
        logic [31:0]       mask;

        ax = it.dx[7] ? (8'd0 - 8'(it.dx)) : 8'(it.dx);
        ay = it.dy[7] ? (8'd0 - 8'(it.dy)) : 8'(it.dy);
        elapsed = it.now_ms - stamp;
        click_limit = 17'(reset_tenths) * aplf_pkg::TENTH_MS;
        mask = it.layer_mask_in;
        r = '0;
        case (it.opcode)
            aplf_pkg::OP_POINTER:
            begin
                if (ax != 0 || ay != 0)
                begin
                    if (state == aplf_pkg::ST_CLICK)
                        stamp = it.now_ms;
                    else if (state == aplf_pkg::ST_WAIT)
                    begin
                        if (enable && it.base_on_top)
                        begin
                            sum = 16'(motion) + 16'(ax) + 16'(ay);
                            motion = (sum > 16'(aplf_pkg::ACC_MAX)) ?
                                     aplf_pkg::ACC_MAX : sum[14:0];
                            if (motion >= threshold)
                            begin
                                motion = '0;
                                stamp = it.now_ms;
                                state = aplf_pkg::ST_CLICK;
                                r.layer_cmd = aplf_pkg::CMD_ON;
                            end
                        end
                    end
                    else
                    begin
                        stamp = it.now_ms;
                        state = aplf_pkg::ST_WAIT;
                        motion = '0;
                    end
                end
                else
                begin
                    if (state == aplf_pkg::ST_CLICK)
                    begin
                        if (17'(elapsed) > click_limit)
                        begin
                            state = aplf_pkg::ST_IDLE;
                            r.layer_cmd = aplf_pkg::CMD_OFF;
                        end
                    end
                    else if (state == aplf_pkg::ST_WAIT)
                    begin
                        if (elapsed > aplf_pkg::WAIT_TIMEOUT_MS)
                        begin
                            motion = '0;
                            state = aplf_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        motion = '0;
                        state = aplf_pkg::ST_IDLE;
                    end
                end
            end
            aplf_pkg::OP_KEY:
            begin
                if (state == aplf_pkg::ST_CLICK)
                begin
                    stamp = it.now_ms;
                    r.layer_cmd = aplf_pkg::CMD_ON;
                end
            end
            aplf_pkg::OP_LAYER:
            begin
                if (state == aplf_pkg::ST_CLICK)
                begin
                    state = aplf_pkg::ST_IDLE;
                    if ((mask & ~aplf_pkg::PTR_LAYER_BIT) != '0)
                        mask = mask & ~aplf_pkg::PTR_LAYER_BIT;
                end
                r.layer_mask_out = mask;
                r.scroll_mode = (mask[31:4] == '0) && mask[3];
            end
            default: ;
        endcase
        r.click_state_out = state;
        r.motion_total = motion;
        return r;
    endfunction

    function void note_item(aplf_pkg::item_t it);
        expected_results.push_back(step_controller(it));
    endfunction

    function int unsigned pending();
        return expected_results.size();
    endfunction

    task report(string msg);
        if (errors < 50)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(aplf_pkg::result_t got);
        aplf_pkg::result_t exp;

        if (expected_results.size() == 0)
        begin
            report("result transaction with no expectation pending");
            return;
        end
        exp = expected_results.pop_front();
        checked++;
        if (exp.layer_cmd == aplf_pkg::CMD_ON)
            layer_on_count++;
        if (exp.layer_cmd == aplf_pkg::CMD_OFF)
            layer_off_count++;
        if (got.layer_cmd !== exp.layer_cmd)
            report($sformatf("result %0d layer_cmd %0d, expected %0d",
                checked, got.layer_cmd, exp.layer_cmd));
        if (got.layer_mask_out !== exp.layer_mask_out)
            report($sformatf("result %0d layer_mask_out %h, expected %h",
                checked, got.layer_mask_out, exp.layer_mask_out));
        if (got.scroll_mode !== exp.scroll_mode)
            report($sformatf("result %0d scroll_mode %0d, expected %0d",
                checked, got.scroll_mode, exp.scroll_mode));
        if (got.click_state_out !== exp.click_state_out)
            report($sformatf("result %0d click_state_out %0d, expected %0d",
                checked, got.click_state_out, exp.click_state_out));
        if (got.motion_total !== exp.motion_total)
            report($sformatf("result %0d motion_total %0d, expected %0d",
                checked, got.motion_total, exp.motion_total));
    endtask
endclass

module testbench;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SENDER = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH = 3;
    localparam int NUM_PHASES = 7;
    localparam int CHUNK_ITEMS = 42;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [aplf_pkg::APB_ADDR_BITS-1:0] paddr = '0;
    logic [aplf_pkg::APB_DATA_BITS-1:0] pwdata = '0;
    logic [aplf_pkg::APB_DATA_BITS-1:0] prdata;
    logic                               pready;

    logic              item_valid = 1'b0;
    logic              item_ready;
    aplf_pkg::item_t   item = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    aplf_pkg::result_t result;

    pointer_layer_scoreboard sb;

    int unsigned     tx_idle_pct = 0;
    int unsigned     rx_stall_pct = 0;
    int unsigned     rx_cycle = 0;
    int unsigned     hold_until = 0;
    int unsigned     idle_cycles = 0;
    int unsigned     sent_count = 0;
    logic [15:0]     clock_ms = 16'd0;
    aplf_pkg::item_t directed[$];

    int unsigned phase_cfg [NUM_PHASES][3] = '{
        '{1, 2, 1},
        '{0, 50, 10},
        '{1, 32767, 999},
        '{1, 300, 0},
        '{1, 1, 1023},
        '{1, 0, 5},
        '{1, 120, 3}
    };

    auto_pointer_layer_fsm_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.note_item(item);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle < hold_until)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic set_idling(int mode);
        tx_idle_pct = (mode == IDLE_SENDER) ? 64 : (mode == IDLE_BOTH) ? 6 : 0;
        rx_stall_pct = (mode == IDLE_RECEIVER) ? 64 : (mode == IDLE_BOTH) ? 6 : 0;
    endtask

    task automatic write_register(logic [1:0] index, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_register(index, value);
    endtask

    task automatic send_item(aplf_pkg::item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        sent_count++;
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic aplf_pkg::item_t make_item(logic [1:0] op, int now, int dx, int dy,
                                                  logic base, logic [31:0] mask);
        aplf_pkg::item_t it;

        it.opcode = op;
        it.now_ms = 16'(now);
        it.dx = 8'(dx);
        it.dy = 8'(dy);
        it.base_on_top = base;
        it.layer_mask_in = mask;
        return it;
    endfunction

    function automatic aplf_pkg::item_t random_item();
        aplf_pkg::item_t it;
        int unsigned     pick;
        int unsigned     step;

        pick = $urandom_range(99);
        if (pick < 55)
            step = $urandom_range(20);
        else if (pick < 78)
            step = $urandom_range(80);
        else if (pick < 84)
            step = 49 + $urandom_range(3);
        else if (pick < 90)
            step = sb.reset_tenths * 100 - 1 + $urandom_range(2);
        else if (pick < 97)
            step = $urandom_range(2000);
        else
            step = $urandom;
        clock_ms = clock_ms + 16'(step);
        it.now_ms = clock_ms;

        pick = $urandom_range(99);
        it.opcode = (pick < 66) ? aplf_pkg::OP_POINTER : (pick < 78) ? aplf_pkg::OP_KEY :
                    (pick < 95) ? aplf_pkg::OP_LAYER : OP_UNUSED;

        pick = $urandom_range(99);
        if (pick < 40)
        begin
            it.dx = '0;
            it.dy = '0;
        end
        else if (pick < 70)
        begin
            it.dx = 8'($urandom_range(20) - 10);
            it.dy = 8'($urandom_range(20) - 10);
        end
        else
        begin
            it.dx = 8'($urandom);
            it.dy = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
        end
        it.base_on_top = ($urandom_range(99) < 85);

        pick = $urandom_range(99);
        if (pick < 40)
            it.layer_mask_in = $urandom;
        else if (pick < 70)
            it.layer_mask_in = 32'($urandom_range(15));
        else if (pick < 80)
            it.layer_mask_in = '0;
        else
            it.layer_mask_in = (32'd1 << $urandom_range(31)) |
                               (($urandom_range(1) == 1) ? aplf_pkg::PTR_LAYER_BIT : 32'd0);
        return it;
    endfunction

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(make_item(OP_UNUSED, 100, 5, 5, 1'b1, 32'hFFFF_FFFF));
        directed.push_back(make_item(aplf_pkg::OP_KEY, 110, 0, 0, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_LAYER, 111, 0, 0, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_LAYER, 112, 0, 0, 1'b1, 32'h0000_000A));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 120, 0, 0, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 130, 3, -4, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 131, 100, 100, 1'b0, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 132, 10, -10, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 170, 0, 0, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 175, -128, 0, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_KEY, 300, 0, 0, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 400, 1, 1, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 1400, 0, 0, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 1401, 0, 0, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 1500, 0, -128, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 1551, 0, 0, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 1600, 127, 127, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 1601, 127, -127, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_LAYER, 1602, 0, 0, 1'b1,
                                     aplf_pkg::PTR_LAYER_BIT));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 1700, 1, 0, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 1701, 127, 127, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_LAYER, 1702, 0, 0, 1'b1, 32'h0000_000A));
        directed.push_back(make_item(aplf_pkg::OP_LAYER, 1703, -1, -1, 1'b0, 32'h8000_0002));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 65530, 2, 2, 1'b1, 32'h0));
        directed.push_back(make_item(aplf_pkg::OP_POINTER, 20, 0, 0, 1'b1, 32'h0));

        set_idling(IDLE_NONE);
        foreach (directed[k])
            send_item(directed[k]);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_register(aplf_pkg::REG_ENABLE, phase_cfg[p][0]);
            write_register(aplf_pkg::REG_THRESHOLD, phase_cfg[p][1]);
            write_register(aplf_pkg::REG_RESET_TIME, phase_cfg[p][2]);
            for (int chunk = 0; chunk < 4; chunk++)
            begin
                set_idling((p + chunk) % 4);
                if (p == 0 && chunk == 0)
                    hold_until = rx_cycle + HOLD_CYCLES;
                for (int n = 0; n < CHUNK_ITEMS; n++)
                    send_item(random_item());
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("Covered %0d transactions over %0d register settings and four idling modes.",
            sent_count, NUM_PHASES + 1);
        $display("Checked %0d results, %0d pointer-layer turn-ons and %0d turn-offs.",
            sb.checked, sb.layer_on_count, sb.layer_off_count);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
